[rtl/narr_pkg.sv]
package narr_pkg;

  // Sample and field widths fixed by the stream format
  localparam int unsigned IN_W   = 24;
  localparam int unsigned GAIN_W = 21;
  localparam int unsigned DAMP_W = 20;
  localparam int unsigned FS_W   = 17;
  localparam int unsigned LEN_W  = 17;
  localparam int unsigned CFG_W  = 21;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned MS_W   = 7;
  localparam int unsigned PROD_W = FS_W + MS_W;

  // Fixed chain gains, Q0.20
  localparam logic [GAIN_W-1:0] G_030 = 21'd314573;
  localparam logic [GAIN_W-1:0] G_050 = 21'd524288;
  localparam logic [GAIN_W-1:0] G_025 = 21'd262144;
  localparam logic [GAIN_W-1:0] M_034 = 21'd356516;
  localparam logic [GAIN_W-1:0] M_014 = 21'd146801;
  localparam logic [GAIN_W-1:0] M_015 = 21'd157286;

  // Divide by 1000 as multiply by ceil(2^34/1000), exact for products below 2^24
  localparam int unsigned         RECIP_W     = 25;
  localparam logic [RECIP_W-1:0]  RECIP_1000  = 25'd17179870;
  localparam int unsigned         RECIP_SHIFT = 34;
  localparam int unsigned         QUOT_W      = 15;

  // Register reset values
  localparam logic [GAIN_W-1:0] DRY_RST  = 21'd1048576;
  localparam logic [GAIN_W-1:0] WET_RST  = 21'd524288;
  localparam logic [GAIN_W-1:0] FB_RST   = 21'd524288;
  localparam logic [DAMP_W-1:0] DAMP_RST = 20'd746270;
  localparam logic [FS_W-1:0]   FS_RST   = 17'd48000;

  typedef enum logic [IDX_W-1:0] {
    REG_DRY  = 3'd0,
    REG_WET  = 3'd1,
    REG_FB   = 3'd2,
    REG_DAMP = 3'd3,
    REG_FS   = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DER_MUL,
    ST_DER_DIV,
    ST_DER_WR,
    ST_FB_MUL,
    ST_IN,
    ST_AP_RD,
    ST_AP_Y,
    ST_AP_MUL,
    ST_AP_WR,
    ST_N1_MUL,
    ST_N1_O2,
    ST_N1_MUL2,
    ST_N1_I3,
    ST_DT_WR,
    ST_DT_RD,
    ST_DT_GET,
    ST_N2_MUL,
    ST_N2_O4,
    ST_N2_MUL2,
    ST_N2_I5,
    ST_LP_MUL,
    ST_LP_UPD,
    ST_WET1,
    ST_WET2,
    ST_WET3,
    ST_WET4,
    ST_WET5,
    ST_WET6,
    ST_WET7
  } state_e;

  // Line length in milliseconds for the seven lines of one channel
  function automatic logic [MS_W-1:0] line_ms(input logic [2:0] line);
    logic [MS_W-1:0] ms;
    case (line)
      3'd0:    ms = 7'd8;
      3'd1:    ms = 7'd12;
      3'd2:    ms = 7'd87;
      3'd3:    ms = 7'd62;
      3'd4:    ms = 7'd120;
      3'd5:    ms = 7'd76;
      3'd6:    ms = 7'd30;
      default: ms = 7'd30;
    endcase
    return ms;
  endfunction

endpackage

[rtl/nested_allpass_room_reverb_top.sv]
// Channel        | Dir | Handshake                    | Payload
// s_axis         | in  | s_axis_tvalid/s_axis_tready  | tdata: left_in, right_in
// m_axis         | out | m_axis_tvalid/m_axis_tready  | tdata: left_out, right_out
// cfg            | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// One stereo frame: the idle state takes the request, then 45 steps per channel, left
// then right, each with at most one multiply and at most one delay memory access. The
// result loads in the right channel's last step. After reset the delay memory is cleared,
// then the line lengths are derived; a sample rate write rederives them. Input is refused
// during both. A finished frame waits in the output register while the next frame is
// taken in; the block stalls at its last step if that is still full.
module nested_allpass_room_reverb_top #(
  parameter int unsigned DELAY_MEMORY_DEPTH  = 131072,
  parameter int unsigned SAMPLE_WIDTH        = 24,
  parameter int unsigned RIGHT_LENGTH_OFFSET = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*narr_pkg::IN_W-1:0]   s_axis_tdata,   // [23:0] left_in, [47:24] right_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*narr_pkg::IN_W-1:0]   m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  input  logic                          cfg_we_i,
  input  logic [narr_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [narr_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned AW   = $clog2(DELAY_MEMORY_DEPTH);
  localparam int unsigned SUMW = ((AW > narr_pkg::LEN_W) ? AW : narr_pkg::LEN_W) + 1;
  localparam int unsigned XW   = (SW > narr_pkg::IN_W) ? SW : narr_pkg::IN_W;
  localparam int unsigned MA   = XW + 1;
  localparam int unsigned MB   = narr_pkg::GAIN_W + 1;
  localparam int unsigned PW   = MA + MB;
  localparam int unsigned ACCW = PW + 2;
  localparam int unsigned WIDE = ACCW + 1;
  localparam int unsigned OW   = narr_pkg::IN_W;

  localparam logic [SUMW-1:0]        DEPTH_S = SUMW'(DELAY_MEMORY_DEPTH);
  localparam logic [AW-1:0]          CLR_END = AW'(DELAY_MEMORY_DEPTH - 1);
  localparam logic signed [WIDE-1:0] SAT_HI  = WIDE'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [WIDE-1:0] SAT_LO  = -SAT_HI - WIDE'(1);
  localparam logic signed [WIDE-1:0] OUT_HI  = WIDE'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [WIDE-1:0] OUT_LO  = -OUT_HI - WIDE'(1);
  localparam logic signed [WIDE-1:0] HALF_W  = WIDE'(524288);
  localparam logic signed [18:0]     OFF_S   = 19'(RIGHT_LENGTH_OFFSET);

  // Saturate to the stored sample width
  function automatic logic signed [SW-1:0] sat_s(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] r;
    r = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return r[SW-1:0];
  endfunction

  // Saturate to the 24 bit output
  function automatic logic signed [OW-1:0] sat_o(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] r;
    r = (v > OUT_HI) ? OUT_HI : ((v < OUT_LO) ? OUT_LO : v);
    return r[OW-1:0];
  endfunction

  // Round a Q.20 product to nearest, ties up
  function automatic logic signed [WIDE-1:0] rnd(input logic signed [WIDE-1:0] v);
    return (v + HALF_W) >>> 20;
  endfunction

  narr_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [narr_pkg::GAIN_W-1:0] dry_q, wet_q, fb_q;
  logic [narr_pkg::DAMP_W-1:0] damp_q;
  logic [narr_pkg::FS_W-1:0]   fs_q;
  logic                        der_pend_q;

  // Line tables
  logic [narr_pkg::LEN_W-1:0] pos_q  [14];
  logic [narr_pkg::LEN_W-1:0] len_q  [14];
  logic [AW-1:0]              base_q [14];

  // Derivation sequencer
  logic                         der_ch_q;
  logic [2:0]                   der_line_q;
  logic [narr_pkg::PROD_W-1:0]  prod_q;
  logic [narr_pkg::QUOT_W-1:0]  quot_q;
  logic [AW-1:0]                base_acc_q;

  // Channel datapath
  logic                         ch_q;
  logic [2:0]                   line_q;
  logic                         dt_sel_q;
  logic signed [OW-1:0]         x_q [2];
  logic signed [SW-1:0]         v_q, y_q, o1_q, o2_q, o4_q;
  logic signed [SW-1:0]         tap_q [4];
  logic signed [SW-1:0]         lp_q  [2];
  logic signed [PW-1:0]         p_q;
  logic signed [ACCW-1:0]       acc_q;
  logic signed [MA-1:0]         ws_q;
  logic signed [OW-1:0]         res_l_q;
  logic [2*OW-1:0]              out_q;
  logic                         out_vld_q;
  logic [AW-1:0]                clr_q;

  // Delay memory
  logic [SW-1:0]                mem [DELAY_MEMORY_DEPTH];
  logic signed [SW-1:0]         rdata_q;
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [SW-1:0]                mem_wdata;

  // Shared multiplier
  logic                         mul_en;
  logic signed [MA-1:0]         mul_a;
  logic signed [MB-1:0]         mul_b;

  logic                         in_req, out_take, stall, last_der;

  // Current line address and position update
  logic [2:0]                   cur_line;
  logic [3:0]                   lidx;
  logic [SUMW-1:0]              asum;
  logic [AW-1:0]                line_addr;
  logic [narr_pkg::LEN_W:0]     pos_inc;
  logic [narr_pkg::LEN_W-1:0]   pos_next;
  logic                         dt_state;

  assign dt_state  = (state_q == narr_pkg::ST_DT_WR) || (state_q == narr_pkg::ST_DT_RD) ||
                     (state_q == narr_pkg::ST_DT_GET);
  assign cur_line  = dt_state ? (dt_sel_q ? 3'd4 : 3'd2) : line_q;
  assign lidx      = ch_q ? (4'(cur_line) + 4'd7) : 4'(cur_line);
  assign asum      = SUMW'(base_q[lidx]) + SUMW'(pos_q[lidx]);
  assign line_addr = (asum >= DEPTH_S) ? AW'(asum - DEPTH_S) : AW'(asum);
  assign pos_inc   = {1'b0, pos_q[lidx]} + (narr_pkg::LEN_W + 1)'(1);
  assign pos_next  = (pos_inc >= {1'b0, len_q[lidx]}) ? '0 : pos_inc[narr_pkg::LEN_W-1:0];

  // Derived length of the line under derivation
  logic signed [18:0]           len_s;
  logic [narr_pkg::LEN_W-1:0]   len_new;
  logic [SUMW-1:0]              base_sum;
  logic [3:0]                   der_idx;
  logic [narr_pkg::PROD_W+narr_pkg::RECIP_W-1:0] div_prod;

  assign div_prod = (narr_pkg::PROD_W + narr_pkg::RECIP_W)'(prod_q) *
                    (narr_pkg::PROD_W + narr_pkg::RECIP_W)'(narr_pkg::RECIP_1000);
  always_comb begin
    len_s = $signed(19'(quot_q));
    if (der_ch_q) begin
      len_s = der_line_q[0] ? (len_s - OFF_S) : (len_s + OFF_S);
    end
    if (len_s < 19'sd1) begin
      len_s = 19'sd1;
    end
  end
  assign len_new  = len_s[narr_pkg::LEN_W-1:0];
  assign base_sum = SUMW'(base_acc_q) + SUMW'(len_new) + SUMW'(1);
  assign der_idx  = der_ch_q ? (4'(der_line_q) + 4'd7) : 4'(der_line_q);
  assign last_der = der_ch_q && (der_line_q == 3'd6);

  // Handshakes
  assign s_axis_tready = (state_q == narr_pkg::ST_IDLE) && !der_pend_q;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign out_take      = out_vld_q && m_axis_tready;
  assign stall         = (state_q == narr_pkg::ST_WET7) && ch_q && out_vld_q && !m_axis_tready;

  // Allpass gain by line
  logic [narr_pkg::GAIN_W-1:0] ap_gain;
  assign ap_gain = (line_q == 3'd0 || line_q == 3'd1) ? narr_pkg::G_030 : narr_pkg::G_025;

  // Wide sums for rounding
  logic signed [WIDE-1:0] p_rnd, out_rnd;
  assign p_rnd   = rnd(WIDE'(p_q));
  assign out_rnd = rnd(WIDE'(acc_q) + WIDE'(p_q));

  // Next state, memory port and multiplier operands
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = line_addr;
    mem_raddr = line_addr;
    mem_wdata = '0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      narr_pkg::ST_IDLE: begin
        if (der_pend_q) begin
          state_d = narr_pkg::ST_DER_MUL;
        end else if (in_req) begin
          state_d = narr_pkg::ST_FB_MUL;
        end
      end
      narr_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == CLR_END) begin
          state_d = narr_pkg::ST_IDLE;
        end
      end
      narr_pkg::ST_DER_MUL: state_d = narr_pkg::ST_DER_DIV;
      narr_pkg::ST_DER_DIV: state_d = narr_pkg::ST_DER_WR;
      narr_pkg::ST_DER_WR:  state_d = last_der ? narr_pkg::ST_IDLE : narr_pkg::ST_DER_MUL;
      narr_pkg::ST_FB_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MA'(lp_q[ch_q]);
        mul_b   = MB'(fb_q);
        state_d = narr_pkg::ST_IN;
      end
      narr_pkg::ST_IN: state_d = narr_pkg::ST_AP_RD;
      narr_pkg::ST_AP_RD: begin
        mem_re  = 1'b1;
        mul_en  = 1'b1;
        mul_a   = MA'(v_q);
        mul_b   = MB'(ap_gain);
        state_d = narr_pkg::ST_AP_Y;
      end
      narr_pkg::ST_AP_Y: state_d = narr_pkg::ST_AP_MUL;
      narr_pkg::ST_AP_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MA'(y_q);
        mul_b   = MB'(ap_gain);
        state_d = narr_pkg::ST_AP_WR;
      end
      narr_pkg::ST_AP_WR: begin
        mem_we    = 1'b1;
        mem_wdata = sat_s(WIDE'(v_q) + p_rnd);
        case (line_q)
          3'd0:    state_d = narr_pkg::ST_AP_RD;
          3'd1:    state_d = narr_pkg::ST_N1_MUL;
          3'd3:    state_d = narr_pkg::ST_DT_WR;
          3'd5:    state_d = narr_pkg::ST_AP_RD;
          default: state_d = narr_pkg::ST_DT_WR;
        endcase
      end
      narr_pkg::ST_N1_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MA'(v_q);
        mul_b   = MB'(narr_pkg::G_050);
        state_d = narr_pkg::ST_N1_O2;
      end
      narr_pkg::ST_N1_O2: state_d = narr_pkg::ST_N1_MUL2;
      narr_pkg::ST_N1_MUL2: begin
        mul_en  = 1'b1;
        mul_a   = MA'(o2_q);
        mul_b   = MB'(narr_pkg::G_050);
        state_d = narr_pkg::ST_N1_I3;
      end
      narr_pkg::ST_N1_I3: state_d = narr_pkg::ST_AP_RD;
      narr_pkg::ST_DT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = v_q;
        state_d   = narr_pkg::ST_DT_RD;
      end
      narr_pkg::ST_DT_RD: begin
        mem_re  = 1'b1;
        state_d = narr_pkg::ST_DT_GET;
      end
      narr_pkg::ST_DT_GET: state_d = dt_sel_q ? narr_pkg::ST_LP_MUL : narr_pkg::ST_N2_MUL;
      narr_pkg::ST_N2_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MA'(o2_q);
        mul_b   = MB'(narr_pkg::G_050);
        state_d = narr_pkg::ST_N2_O4;
      end
      narr_pkg::ST_N2_O4: state_d = narr_pkg::ST_N2_MUL2;
      narr_pkg::ST_N2_MUL2: begin
        mul_en  = 1'b1;
        mul_a   = MA'(o4_q);
        mul_b   = MB'(narr_pkg::G_050);
        state_d = narr_pkg::ST_N2_I5;
      end
      narr_pkg::ST_N2_I5: state_d = narr_pkg::ST_AP_RD;
      narr_pkg::ST_LP_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MA'(lp_q[ch_q]) - MA'(o4_q);
        mul_b   = MB'(damp_q);
        state_d = narr_pkg::ST_LP_UPD;
      end
      narr_pkg::ST_LP_UPD: state_d = narr_pkg::ST_WET1;
      narr_pkg::ST_WET1: begin
        mul_en  = 1'b1;
        mul_a   = MA'(o1_q);
        mul_b   = MB'(narr_pkg::M_034);
        state_d = narr_pkg::ST_WET2;
      end
      narr_pkg::ST_WET2: begin
        mul_en  = 1'b1;
        mul_a   = MA'(o2_q);
        mul_b   = MB'(narr_pkg::M_014);
        state_d = narr_pkg::ST_WET3;
      end
      narr_pkg::ST_WET3: begin
        mul_en  = 1'b1;
        mul_a   = MA'(o4_q);
        mul_b   = MB'(narr_pkg::M_015);
        state_d = narr_pkg::ST_WET4;
      end
      narr_pkg::ST_WET4: state_d = narr_pkg::ST_WET5;
      narr_pkg::ST_WET5: begin
        mul_en  = 1'b1;
        mul_a   = MA'(x_q[ch_q]);
        mul_b   = MB'(dry_q);
        state_d = narr_pkg::ST_WET6;
      end
      narr_pkg::ST_WET6: begin
        mul_en  = 1'b1;
        mul_a   = ws_q;
        mul_b   = MB'(wet_q);
        state_d = narr_pkg::ST_WET7;
      end
      narr_pkg::ST_WET7: begin
        if (!ch_q) begin
          state_d = narr_pkg::ST_FB_MUL;
        end else if (!stall) begin
          state_d = narr_pkg::ST_IDLE;
        end
      end
      default: state_d = narr_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= narr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Delay memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Configuration, control and kept state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q      <= narr_pkg::DRY_RST;
      wet_q      <= narr_pkg::WET_RST;
      fb_q       <= narr_pkg::FB_RST;
      damp_q     <= narr_pkg::DAMP_RST;
      fs_q       <= narr_pkg::FS_RST;
      der_pend_q <= 1'b1;
      clr_q      <= '0;
      der_ch_q   <= 1'b0;
      der_line_q <= '0;
      base_acc_q <= '0;
      ch_q       <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < 14; i++) begin
        pos_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        tap_q[i] <= '0;
      end
      lp_q[0] <= '0;
      lp_q[1] <= '0;
    end else begin
      // derivation request consumed on entry, a new rate write wins
      if (state_q == narr_pkg::ST_IDLE && der_pend_q) begin
        der_pend_q <= 1'b0;
        der_ch_q   <= 1'b0;
        der_line_q <= '0;
        base_acc_q <= '0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          narr_pkg::REG_DRY:  dry_q  <= cfg_data_i;
          narr_pkg::REG_WET:  wet_q  <= cfg_data_i;
          narr_pkg::REG_FB:   fb_q   <= cfg_data_i;
          narr_pkg::REG_DAMP: damp_q <= cfg_data_i[narr_pkg::DAMP_W-1:0];
          narr_pkg::REG_FS: begin
            fs_q       <= cfg_data_i[narr_pkg::FS_W-1:0];
            der_pend_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state_q == narr_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      // step to the next line and its base
      if (state_q == narr_pkg::ST_DER_WR) begin
        base_acc_q <= (base_sum >= DEPTH_S) ? AW'(base_sum - DEPTH_S) : AW'(base_sum);
        if (der_line_q == 3'd6) begin
          der_line_q <= '0;
          der_ch_q   <= 1'b1;
        end else begin
          der_line_q <= der_line_q + 3'd1;
        end
      end
      if (in_req) begin
        ch_q <= 1'b0;
      end
      if (state_q == narr_pkg::ST_AP_WR || state_q == narr_pkg::ST_DT_WR) begin
        pos_q[lidx] <= pos_next;
      end
      if (state_q == narr_pkg::ST_DT_GET) begin
        tap_q[{ch_q, dt_sel_q}] <= rdata_q;
      end
      if (state_q == narr_pkg::ST_LP_UPD) begin
        lp_q[ch_q] <= sat_s(WIDE'(o4_q) + p_rnd);
      end
      if (state_q == narr_pkg::ST_WET7 && !ch_q) begin
        ch_q <= 1'b1;
      end
      // output register
      if (state_q == narr_pkg::ST_WET7 && ch_q && !stall) begin
        out_vld_q <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en && !stall) begin
      p_q <= PW'(mul_a * mul_b);
    end
    if (state_q == narr_pkg::ST_DER_MUL) begin
      prod_q <= narr_pkg::PROD_W'(fs_q) * narr_pkg::PROD_W'(narr_pkg::line_ms(der_line_q));
    end
    if (state_q == narr_pkg::ST_DER_DIV) begin
      quot_q <= div_prod[narr_pkg::RECIP_SHIFT +: narr_pkg::QUOT_W];
    end
    if (state_q == narr_pkg::ST_DER_WR) begin
      len_q[der_idx]  <= len_new;
      base_q[der_idx] <= base_acc_q;
    end
    if (in_req) begin
      x_q[0] <= s_axis_tdata[OW-1:0];
      x_q[1] <= s_axis_tdata[2*OW-1:OW];
    end
    case (state_q)
      narr_pkg::ST_IN: begin
        v_q    <= sat_s(WIDE'(x_q[ch_q]) + p_rnd);
        line_q <= 3'd0;
      end
      narr_pkg::ST_AP_Y: y_q <= sat_s(WIDE'(rdata_q) - p_rnd);
      narr_pkg::ST_AP_WR: begin
        v_q <= y_q;
        if (line_q == 3'd0) begin
          line_q <= 3'd1;
        end else if (line_q == 3'd5) begin
          line_q <= 3'd6;
        end
        dt_sel_q <= (line_q == 3'd6);
      end
      narr_pkg::ST_N1_MUL: o1_q <= v_q;
      narr_pkg::ST_N1_O2:  o2_q <= sat_s(WIDE'(tap_q[{ch_q, 1'b0}]) - p_rnd);
      narr_pkg::ST_N1_I3: begin
        v_q    <= sat_s(WIDE'(o1_q) + p_rnd);
        line_q <= 3'd3;
      end
      narr_pkg::ST_N2_O4:  o4_q <= sat_s(WIDE'(tap_q[{ch_q, 1'b1}]) - p_rnd);
      narr_pkg::ST_N2_I5: begin
        v_q    <= sat_s(WIDE'(o2_q) + p_rnd);
        line_q <= 3'd5;
      end
      narr_pkg::ST_WET2: acc_q <= ACCW'(p_q);
      narr_pkg::ST_WET3: acc_q <= acc_q + ACCW'(p_q);
      narr_pkg::ST_WET4: acc_q <= acc_q + ACCW'(p_q);
      narr_pkg::ST_WET5: ws_q  <= MA'(rnd(WIDE'(acc_q)));
      narr_pkg::ST_WET6: acc_q <= ACCW'(p_q);
      narr_pkg::ST_WET7: begin
        if (!ch_q) begin
          res_l_q <= sat_o(out_rnd);
        end else if (!stall) begin
          out_q <= {sat_o(out_rnd), res_l_q};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // An accepted frame starts the left channel's feedback step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> (state_q == narr_pkg::ST_FB_MUL) && !ch_q)
    else $error("accepted frame did not start processing");

  // Memory writes stay inside the memory
  a_waddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (SUMW'(mem_waddr) < DEPTH_S))
    else $error("delay memory write out of range");

  // No datapath read and no input ready while the memory is being cleared
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == narr_pkg::ST_CLEAR) |-> !mem_re && !s_axis_tready)
    else $error("access during clear pass");

  // A result is only loaded after the right channel finishes
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_vld_q && $past(out_vld_q) == 1'b0 && out_vld_q == 1'b0) ||
    !$rose(out_vld_q) || ($past(state_q) == narr_pkg::ST_WET7 && $past(ch_q)))
    else $error("output loaded outside the final step");
`endif

endmodule
